/* rtl/bums_pkg.sv */
`timescale 1ns / 1ps

package bums_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CMP_W   = 9;

  localparam logic [CMP_W-1:0] CMP_MAX = '1;

  // Status the merge sequencer reports to the top level.
  typedef struct packed {
    logic             done;           // one-cycle pulse when the sort has finished
    logic             bank;           // memory that holds the source (and final) data
    logic [CMP_W-1:0] compare_count;  // comparisons made for the current set
  } sort_status_t;

endpackage

/* rtl/bums_if.sv */
`timescale 1ns / 1ps

interface bums_in_if;
  import bums_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface bums_out_if;
  import bums_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sorted_value;
  logic        [CMP_W-1:0]   compare_count;
  logic                      overflow;
  logic                      last_out;

  modport source (output valid, output sorted_value, output compare_count,
                  output overflow, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input compare_count,
                  input overflow, input last_out, output ready);
endinterface

/* rtl/bums_ram.sv */
`timescale 1ns / 1ps

module bums_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 32,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bums_merge.sv */
`timescale 1ns / 1ps

module bums_merge #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            start_i,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]                  n_i,
  input  logic [bums_pkg::VALUE_W-1:0]                    rdata_a_i,
  input  logic [bums_pkg::VALUE_W-1:0]                    rdata_b_i,
  output logic                                            rd_en_o,
  output logic [$clog2(MAX_ITEMS)-1:0]                    rd_addr_o,
  output logic                                            wr_en_o,
  output logic [$clog2(MAX_ITEMS)-1:0]                    wr_addr_o,
  output logic [bums_pkg::VALUE_W-1:0]                    wr_data_o,
  output bums_pkg::sort_status_t                          status_o
);
  import bums_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SUM_W = CNT_W + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_RD_L,
    S_RD_R,
    S_CAP_R,
    S_CMP,
    S_WAIT_L,
    S_WAIT_R
  } state_e;

  state_e                    state_q;
  logic                      src_q;
  logic                      done_q;
  logic [CNT_W-1:0]          n_q, w_q, j_q, l_q, r_q, k_q, mid_q, hi_q;
  logic signed [VALUE_W-1:0] left_q, right_q;
  logic [CMP_W-1:0]          cmp_q;

  logic [VALUE_W-1:0] rdata_src;
  logic [SUM_W-1:0]   n_ext, mid_sum, hi_sum, w2_sum;
  logic [CNT_W-1:0]   mid_d, hi_d, l_inc, r_inc;
  logic               l_has, r_has, take_left;

  assign rdata_src = src_q ? rdata_b_i : rdata_a_i;

  always_comb begin
    n_ext   = SUM_W'(n_q);
    w2_sum  = SUM_W'(w_q) << 1;
    mid_sum = SUM_W'(j_q) + SUM_W'(w_q);
    hi_sum  = SUM_W'(j_q) + w2_sum;
    mid_d   = (mid_sum < n_ext) ? CNT_W'(mid_sum) : n_q;
    hi_d    = (hi_sum < n_ext) ? CNT_W'(hi_sum) : n_q;
    l_inc   = l_q + CNT_W'(1);
    r_inc   = r_q + CNT_W'(1);
    l_has   = (l_q < mid_q);
    r_has   = (r_q < hi_q);
    // A tie takes the left element, which keeps the sort stable.
    take_left = l_has && (!r_has || (left_q <= right_q));
  end

  always_comb begin
    rd_en_o   = 1'b0;
    rd_addr_o = l_q[IDX_W-1:0];
    unique case (state_q)
      S_RD_L: begin
        rd_en_o   = l_has;
        rd_addr_o = l_q[IDX_W-1:0];
      end
      S_RD_R: begin
        rd_en_o   = r_has;
        rd_addr_o = r_q[IDX_W-1:0];
      end
      S_CMP: begin
        if (take_left) begin
          rd_en_o   = (l_inc < mid_q);
          rd_addr_o = l_inc[IDX_W-1:0];
        end else begin
          rd_en_o   = r_has && (r_inc < hi_q);
          rd_addr_o = r_inc[IDX_W-1:0];
        end
      end
      default: begin
        rd_en_o   = 1'b0;
        rd_addr_o = l_q[IDX_W-1:0];
      end
    endcase
  end

  assign wr_en_o   = (state_q == S_CMP) && (l_has || r_has);
  assign wr_addr_o = k_q[IDX_W-1:0];
  assign wr_data_o = take_left ? left_q : right_q;

  assign status_o.done          = done_q;
  assign status_o.bank          = src_q;
  assign status_o.compare_count = cmp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      src_q   <= 1'b0;
      done_q  <= 1'b0;
      n_q     <= '0;
      w_q     <= '0;
      j_q     <= '0;
      l_q     <= '0;
      r_q     <= '0;
      k_q     <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      left_q  <= '0;
      right_q <= '0;
      cmp_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            n_q   <= n_i;
            cmp_q <= '0;
            src_q <= 1'b0;
            w_q   <= CNT_W'(1);
            j_q   <= '0;
            if (n_i <= CNT_W'(1)) begin
              done_q <= 1'b1;
            end else begin
              state_q <= S_INIT;
            end
          end
        end
        S_INIT: begin
          mid_q   <= mid_d;
          hi_q    <= hi_d;
          l_q     <= j_q;
          r_q     <= mid_d;
          k_q     <= j_q;
          state_q <= S_RD_L;
        end
        S_RD_L: begin
          state_q <= S_RD_R;
        end
        S_RD_R: begin
          left_q  <= rdata_src;
          state_q <= S_CAP_R;
        end
        S_CAP_R: begin
          right_q <= rdata_src;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (l_has || r_has) begin
            if (l_has && r_has && (cmp_q != CMP_MAX)) begin
              cmp_q <= cmp_q + CMP_W'(1);
            end
            k_q <= k_q + CNT_W'(1);
            if (take_left) begin
              l_q     <= l_inc;
              state_q <= S_WAIT_L;
            end else begin
              r_q     <= r_inc;
              state_q <= S_WAIT_R;
            end
          end else if (hi_sum < n_ext) begin
            j_q     <= CNT_W'(hi_sum);
            state_q <= S_INIT;
          end else begin
            // End of a pass: the destination becomes the next source.
            src_q <= ~src_q;
            if (w2_sum < n_ext) begin
              w_q     <= CNT_W'(w2_sum);
              j_q     <= '0;
              state_q <= S_INIT;
            end else begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        S_WAIT_L: begin
          left_q  <= rdata_src;
          state_q <= S_CMP;
        end
        S_WAIT_R: begin
          right_q <= rdata_src;
          state_q <= S_CMP;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/bottom_up_merge_sort_unit.sv */
`timescale 1ns / 1ps

// Bottom-up merge sort of up to MAX_ITEMS signed 32-bit values. Values are
// loaded one per cycle until a transfer marked last_in; values beyond
// capacity are dropped and flag overflow on every result of the set. The set
// is then sorted ascending and stably in two memories used as ping-pong
// buffers: each pass of run width 1, 2, 4 and so on reads one memory and
// writes the other. Each merged element takes a compare state and a wait
// state, because each comparison waits for the read of the next head
// element. Each merge opens with the init, left-read, right-read and capture
// states and closes in the compare state, and all passes together hold
// close to N merges. Results then leave one at a time, each read, captured
// and held until it is taken, each with the set's comparison count, the
// final one marked last_out. No input is taken while a set is being sorted
// or sent out.
module bottom_up_merge_sort_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bums_in_if.sink           in_i,
  bums_out_if.source        out_o
);
  import bums_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT,
    ST_OUT_RD,
    ST_OUT_CAP,
    ST_OUT_WAIT
  } state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          count_q;
  logic [CNT_W-1:0]          idx_q;
  logic                      drop_q;
  logic                      start_q;
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic [CMP_W-1:0]          out_count_q;
  logic                      out_overflow_q;
  logic                      out_last_q;

  logic               in_xfer, out_xfer, load_we;
  logic               mg_rd_en, mg_wr_en;
  logic [IDX_W-1:0]   mg_rd_addr, mg_wr_addr;
  logic [VALUE_W-1:0] mg_wr_data;
  sort_status_t       mg_status;

  logic               a_we, b_we, ram_re;
  logic [IDX_W-1:0]   a_waddr, ram_raddr;
  logic [VALUE_W-1:0] a_wdata, rdata_a, rdata_b;

  assign in_i.ready = (state_q == ST_LOAD);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;
  assign load_we    = in_xfer && (count_q < CNT_W'(MAX_ITEMS));

  // Memory A takes the loaded set; during the sort each memory is written
  // when it is the destination of the current pass.
  assign a_we      = load_we || (mg_wr_en && mg_status.bank);
  assign a_waddr   = load_we ? count_q[IDX_W-1:0] : mg_wr_addr;
  assign a_wdata   = load_we ? in_i.value : mg_wr_data;
  assign b_we      = mg_wr_en && !mg_status.bank;
  assign ram_re    = mg_rd_en || (state_q == ST_OUT_RD);
  assign ram_raddr = (state_q == ST_SORT) ? mg_rd_addr : idx_q[IDX_W-1:0];

  bums_ram #(
    .DEPTH  (MAX_ITEMS),
    .DATA_W (VALUE_W),
    .ADDR_W (IDX_W)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata_a)
  );

  bums_ram #(
    .DEPTH  (MAX_ITEMS),
    .DATA_W (VALUE_W),
    .ADDR_W (IDX_W)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (mg_wr_addr),
    .wdata_i (mg_wr_data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata_b)
  );

  bums_merge #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .n_i       (count_q),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .rd_en_o   (mg_rd_en),
    .rd_addr_o (mg_rd_addr),
    .wr_en_o   (mg_wr_en),
    .wr_addr_o (mg_wr_addr),
    .wr_data_o (mg_wr_data),
    .status_o  (mg_status)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.sorted_value  = out_value_q;
  assign out_o.compare_count = out_count_q;
  assign out_o.overflow      = out_overflow_q;
  assign out_o.last_out      = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_LOAD;
      count_q        <= '0;
      idx_q          <= '0;
      drop_q         <= 1'b0;
      start_q        <= 1'b0;
      out_valid_q    <= 1'b0;
      out_value_q    <= '0;
      out_count_q    <= '0;
      out_overflow_q <= 1'b0;
      out_last_q     <= 1'b0;
    end else begin
      start_q <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          if (in_xfer) begin
            if (load_we) begin
              count_q <= count_q + CNT_W'(1);
            end else begin
              drop_q <= 1'b1;
            end
            if (in_i.last_in) begin
              start_q <= 1'b1;
              state_q <= ST_SORT;
            end
          end
        end
        ST_SORT: begin
          if (mg_status.done) begin
            idx_q   <= '0;
            state_q <= ST_OUT_RD;
          end
        end
        ST_OUT_RD: begin
          state_q <= ST_OUT_CAP;
        end
        ST_OUT_CAP: begin
          out_value_q    <= mg_status.bank ? rdata_b : rdata_a;
          out_count_q    <= mg_status.compare_count;
          out_overflow_q <= drop_q;
          out_last_q     <= (idx_q + CNT_W'(1) == count_q);
          out_valid_q    <= 1'b1;
          state_q        <= ST_OUT_WAIT;
        end
        ST_OUT_WAIT: begin
          if (out_xfer) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              count_q <= '0;
              drop_q  <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              idx_q   <= idx_q + CNT_W'(1);
              state_q <= ST_OUT_RD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
